[rtl/rdnss_pkg.sv]
`default_nettype none
package rdnss_pkg;

    localparam int NUM_IFACES        = 2;
    localparam int ENTRIES_PER_IFACE = 4;
    localparam int IF_W              = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int ENT_W             = (ENTRIES_PER_IFACE > 1) ? $clog2(ENTRIES_PER_IFACE) : 1;
    localparam int CNT_W             = $clog2(ENTRIES_PER_IFACE + 1);
    localparam int SLOTS             = NUM_IFACES * ENTRIES_PER_IFACE;
    localparam int SLOT_W            = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [19:0] TPS_RESET = 20'd100;
    localparam logic [31:0] LIFE_INF  = 32'hFFFF_FFFF;

    localparam logic [1:0] FUNC_OPTION = 2'd0;
    localparam logic [1:0] FUNC_SNAP   = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  iface;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [31:0] lifetime;
        logic [31:0] now;
    } in_word_t;

    typedef struct packed {
        logic [63:0] out_addr_hi;
        logic [63:0] out_addr_lo;
        logic        entry_valid;
        logic        flag;
        logic        last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_OPT_APPLY,
        ST_SHIFT,
        ST_EXP_MUL,
        ST_EXP_CHK,
        ST_SNAP_SCAN,
        ST_SNAP_DUP,
        ST_EMIT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/rdnss_due_unit.sv]
`default_nettype none
// Expiry compare: registered multiply of life by tick rate, then age compare.
module rdnss_due_unit
    import rdnss_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [31:0] life,
    input  wire logic [19:0] tps,
    input  wire logic [31:0] stamp,
    input  wire logic [31:0] now,
    output logic             due
);
    logic [51:0] limit_reg;
    logic        skip_reg;
    logic [31:0] age_reg;

    // stage 1: product and special cases
    always_ff @(posedge aclk) begin
        limit_reg <= life * {32'd0, tps};
        skip_reg  <= (life == 32'd0) || (life == LIFE_INF) || (tps == 20'd0);
        age_reg   <= now - stamp;
    end

    // stage 2: compare
    assign due = !skip_reg && (limit_reg[51:32] == 20'd0) &&
                 ({20'd0, age_reg} >= limit_reg);
endmodule
`default_nettype wire

[rtl/rdnss_resolver_table.sv]
`default_nettype none
// Flow from accept to result: an option on a bad interface goes straight to the
// result, else searches the interface's entries and compacts on a removal. A query
// sweeps every stored entry for expiry, unless a change is pending; a snapshot sweeps
// too, compacts expired entries and lists unique ones, one word per cycle on m_ready.
// Throughput: one item at a time; s_ready returns once the last word is registered.
// Sync active-low reset clears counts, change flag, tick rate (100); not the store.
module rdnss_resolver_table
    import rdnss_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data,
    input  wire logic      cfg_we,
    input  wire logic [19:0] cfg_data
);
    state_t state_reg, state_next;
    in_word_t item_reg;
    logic [19:0] tps_reg;
    logic [CNT_W-1:0] cnt_reg [NUM_IFACES];
    logic pend_reg, pend_next;
    logic [63:0] ehi [SLOTS];
    logic [63:0] elo [SLOTS];
    logic [31:0] elife [SLOTS];
    logic [31:0] estamp [SLOTS];

    logic [IF_W-1:0]  f_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] n_reg;
    logic             found_reg;
    logic             chg_reg;
    logic             qhit_reg;
    logic             res_flag_reg;
    logic [63:0] sh [ENTRIES_PER_IFACE];
    logic [63:0] sl [ENTRIES_PER_IFACE];
    logic [CNT_W-1:0] sc_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;
    out_word_t out_reg;
    logic      out_v_reg;

    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] slot1;
    logic [ENT_W-1:0]  i_ent;
    logic              due;
    logic              iface_ok;

    assign i_ent = i_reg[ENT_W-1:0];
    assign slot  = SLOT_W'(f_reg) * SLOT_W'(ENTRIES_PER_IFACE) + SLOT_W'(i_ent);
    assign slot1 = slot + SLOT_W'(1);
    assign iface_ok = {29'd0, item_reg.iface} < 32'(NUM_IFACES);

    rdnss_due_unit u_due (
        .aclk  (aclk),
        .life  (elife[slot]),
        .tps   (tps_reg),
        .stamp (estamp[slot]),
        .now   (item_reg.now),
        .due   (due)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    logic last_if;
    assign last_if = (32'(f_reg) == NUM_IFACES - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) begin
                case (s_data.func)
                    FUNC_OPTION: state_next = ST_FIND;
                    FUNC_SNAP, FUNC_QUERY: state_next = ST_EXP_MUL;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_FIND: begin
                if (!iface_ok) state_next = ST_DONE;
                else if (i_reg == cnt_reg[f_reg]) state_next = ST_OPT_APPLY;
                else if (ehi[slot] == item_reg.addr_hi && elo[slot] == item_reg.addr_lo)
                    state_next = ST_OPT_APPLY;
            end
            ST_OPT_APPLY: begin
                if (item_reg.lifetime == 32'd0 && found_reg) state_next = ST_SHIFT;
                else state_next = ST_DONE;
            end
            ST_SHIFT: begin
                if (i_reg + CNT_W'(1) >= n_reg)
                    state_next = (item_reg.func == FUNC_OPTION) ? ST_DONE : ST_EXP_MUL;
            end
            ST_EXP_MUL: begin
                if (item_reg.func == FUNC_QUERY && (pend_reg || qhit_reg))
                    state_next = ST_DONE;
                else if (i_reg >= cnt_reg[f_reg]) begin
                    if (last_if)
                        state_next = (item_reg.func == FUNC_QUERY) ? ST_DONE :
                                     (pend_reg ? ST_SNAP_SCAN : ST_DONE);
                end else state_next = ST_EXP_CHK;
            end
            ST_EXP_CHK: begin
                if (due && item_reg.func == FUNC_SNAP) state_next = ST_SHIFT;
                else state_next = ST_EXP_MUL;
            end
            ST_SNAP_SCAN: begin
                if (sc_reg == CNT_W'(ENTRIES_PER_IFACE) ||
                    (i_reg >= cnt_reg[f_reg] && last_if))
                    state_next = ST_EMIT;
                else if (i_reg < cnt_reg[f_reg]) state_next = ST_SNAP_DUP;
            end
            ST_SNAP_DUP: begin
                if (j_reg == sc_reg) state_next = ST_SNAP_SCAN;
                else if (sh[j_reg[ENT_W-1:0]] == ehi[slot] &&
                         sl[j_reg[ENT_W-1:0]] == elo[slot])
                    state_next = ST_SNAP_SCAN;
            end
            ST_EMIT: begin
                if (!out_v_reg || m_ready)
                    if (sc_reg == CNT_W'(0) || k_reg + CNT_W'(1) == sc_reg)
                        state_next = ST_IDLE;
            end
            ST_DONE: if (!out_v_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // change flag next value
    always_comb begin
        pend_next = pend_reg;
        if (state_reg == ST_SHIFT && state_next != ST_SHIFT) pend_next = 1'b1;
        if (state_reg == ST_OPT_APPLY && chg_reg) pend_next = 1'b1;
        if (state_reg == ST_OPT_APPLY && item_reg.lifetime != 32'd0 &&
            !found_reg && n_reg < CNT_W'(ENTRIES_PER_IFACE)) pend_next = 1'b1;
        if (state_reg == ST_SNAP_SCAN && state_next == ST_EMIT) pend_next = 1'b0;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            tps_reg   <= TPS_RESET;
            out_v_reg <= 1'b0;
            for (int q = 0; q < NUM_IFACES; q++) cnt_reg[q] <= '0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (cfg_we) tps_reg <= cfg_data;
            if ((state_reg == ST_DONE || state_reg == ST_EMIT) && (!out_v_reg || m_ready))
                out_v_reg <= 1'b1;
            else if (m_ready)
                out_v_reg <= 1'b0;
            if (state_reg == ST_OPT_APPLY && item_reg.lifetime != 32'd0 &&
                !found_reg && n_reg < CNT_W'(ENTRIES_PER_IFACE))
                cnt_reg[f_reg] <= n_reg + CNT_W'(1);
            if (state_reg == ST_SHIFT && state_next != ST_SHIFT)
                cnt_reg[f_reg] <= n_reg - CNT_W'(1);
        end
    end

    // after an expiry shift, rescan from the slot that was removed
    function automatic logic [CNT_W-1:0] saved_i(input logic [CNT_W-1:0] n);
        saved_i = (j_reg < n) ? j_reg : n;
    endfunction

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                item_reg     <= s_data;
                f_reg        <= (s_data.func == FUNC_OPTION) ? IF_W'(s_data.iface) : '0;
                i_reg        <= '0;
                found_reg    <= 1'b0;
                chg_reg      <= 1'b0;
                qhit_reg     <= 1'b0;
                res_flag_reg <= 1'b0;
                sc_reg       <= '0;
                k_reg        <= '0;
                j_reg        <= '0;
            end
            ST_FIND: begin
                n_reg <= cnt_reg[f_reg];
                if (state_next == ST_OPT_APPLY) begin
                    found_reg <= (i_reg != cnt_reg[f_reg]);
                end else if (state_next == ST_FIND && i_reg != cnt_reg[f_reg])
                    i_reg <= i_reg + CNT_W'(1);
            end
            ST_OPT_APPLY: begin
                if (item_reg.lifetime == 32'd0) begin
                    res_flag_reg <= found_reg;
                end else begin
                    if (!found_reg && n_reg < CNT_W'(ENTRIES_PER_IFACE)) begin
                        ehi[slot] <= item_reg.addr_hi;
                        elo[slot] <= item_reg.addr_lo;
                        res_flag_reg <= 1'b1;
                    end
                    if (found_reg || n_reg < CNT_W'(ENTRIES_PER_IFACE)) begin
                        elife[slot]  <= item_reg.lifetime;
                        estamp[slot] <= item_reg.now;
                    end
                end
            end
            ST_SHIFT: begin
                if (i_reg + CNT_W'(1) < n_reg) begin
                    ehi[slot]    <= ehi[slot1];
                    elo[slot]    <= elo[slot1];
                    elife[slot]  <= elife[slot1];
                    estamp[slot] <= estamp[slot1];
                    i_reg <= i_reg + CNT_W'(1);
                end else if (item_reg.func != FUNC_OPTION) begin
                    i_reg <= saved_i(n_reg);
                end
            end
            ST_EXP_MUL: begin
                n_reg <= cnt_reg[f_reg];
                if (i_reg >= cnt_reg[f_reg] && !last_if) begin
                    f_reg <= f_reg + IF_W'(1);
                    i_reg <= '0;
                end else if (i_reg >= cnt_reg[f_reg] && last_if) begin
                    f_reg <= '0;
                    i_reg <= '0;
                end
                res_flag_reg <= (item_reg.func == FUNC_QUERY) && (pend_reg || qhit_reg);
            end
            ST_EXP_CHK: begin
                if (due) begin
                    if (item_reg.func == FUNC_QUERY) qhit_reg <= 1'b1;
                    else j_reg <= i_reg;
                end else i_reg <= i_reg + CNT_W'(1);
            end
            ST_SNAP_SCAN: begin
                j_reg <= '0;
                if (i_reg >= cnt_reg[f_reg] && !last_if) begin
                    f_reg <= f_reg + IF_W'(1);
                    i_reg <= '0;
                end
            end
            ST_SNAP_DUP: begin
                if (j_reg == sc_reg) begin
                    sh[sc_reg[ENT_W-1:0]] <= ehi[slot];
                    sl[sc_reg[ENT_W-1:0]] <= elo[slot];
                    sc_reg <= sc_reg + CNT_W'(1);
                    i_reg  <= i_reg + CNT_W'(1);
                end else if (state_next == ST_SNAP_SCAN) begin
                    i_reg <= i_reg + CNT_W'(1);
                end else j_reg <= j_reg + CNT_W'(1);
            end
            ST_EMIT: begin
                if (!out_v_reg || m_ready) begin
                    out_reg.flag <= 1'b1;
                    if (sc_reg == CNT_W'(0)) begin
                        out_reg.out_addr_hi <= '0;
                        out_reg.out_addr_lo <= '0;
                        out_reg.entry_valid <= 1'b0;
                        out_reg.last        <= 1'b1;
                    end else begin
                        out_reg.out_addr_hi <= sh[k_reg[ENT_W-1:0]];
                        out_reg.out_addr_lo <= sl[k_reg[ENT_W-1:0]];
                        out_reg.entry_valid <= 1'b1;
                        out_reg.last        <= (k_reg + CNT_W'(1) == sc_reg);
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
            end
            // single-word result, loaded once the output register is free
            ST_DONE: begin
                if (!out_v_reg || m_ready)
                    out_reg <= {64'd0, 64'd0, 1'b0, res_flag_reg, 1'b1};
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire
